// ----- rtl/tdt_pkg.sv -----
// Shared types and codes for the deferred event timer table.
`default_nettype none

package tdt_pkg;

  // Field widths fixed by the interface
  localparam int OP_W   = 2;
  localparam int CD_W   = 16;
  localparam int TGT_W  = 4;
  localparam int EV_W   = 8;
  localparam int SLOT_W = 5;
  localparam int KIND_W = 2;
  localparam int DIV_W  = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  // One stored timer
  typedef struct packed {
    logic [CD_W-1:0]  countdown;
    logic [TGT_W-1:0] target;
    logic [EV_W-1:0]  ev;
  } slot_entry_t;

  // Divider status seen by the controller
  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/tdt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tdt_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tdt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tdt_pkg::DIV_W-1:0]  dividend,
  input  logic [tdt_pkg::DIV_W-1:0]  divisor,
  output tdt_pkg::div_status_t       status
);

  localparam int DivW = tdt_pkg::DIV_W;
  localparam int CntW = $clog2(DivW);
  localparam logic [CntW-1:0] LastStep = CntW'(DivW - 1);

  logic            busy;
  logic [CntW-1:0] count;
  logic [DivW-1:0] rem;
  logic [DivW-1:0] quo;
  logic [DivW-1:0] dvsr;

  logic [DivW:0] trial;
  logic [DivW:0] diff;
  logic          ge;

  assign trial = {rem, quo[DivW-1]};
  assign ge    = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + CntW'(1);
      if (count == LastStep) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      // keep the partial remainder below the divisor
      rem <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo <= {quo[DivW-2:0], ge};
    end
  end

  assign status.busy      = busy;
  assign status.quotient  = quo;
  assign status.remainder = rem;

endmodule

`default_nettype wire

// ----- rtl/deferred_event_timer_table_top.sv -----
// Top level of the deferred event timer table: control sequencer, slot memories, divider.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   config  | in        | cfg_wr_en            | cfg_wr_data (tick_divisor)
//   request | in        | in_valid / in_ready  | opcode, delay_ticks, target_id, event_code,
//           |           |                      | cancel_slot, elapsed_time
//   result  | out       | out_valid / out_ready| reply_kind, set_ok, slot_number,
//           |           |                      | fired_target, fired_event, last_of_run
//
// Sequence: cancel is accepted and then replies; set scans the busy flags one slot a cycle for a
// free slot; tick waits on the bit-serial divider, then walks the slots one by one, with an extra
// memory-read step for each active slot, and ends with the reply.
// One request is in flight at a time; in_ready is high only between requests.
// Reset: synchronous; clears the busy flags (every slot free), the time remainder and sets the
// divisor to 1. The slot memories are not cleared; a slot is read only while its busy flag is set.
// Stalls: a result beat waits in the output register; the sequencer holds when it has a further
// beat to hand over and the register is still full.
`default_nettype none

module deferred_event_timer_table_top #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdt_pkg::OP_W-1:0]     opcode,
  input  logic [tdt_pkg::CD_W-1:0]     delay_ticks,
  input  logic [tdt_pkg::TGT_W-1:0]    target_id,
  input  logic [tdt_pkg::EV_W-1:0]     event_code,
  input  logic [tdt_pkg::SLOT_W-1:0]   cancel_slot,
  input  logic [tdt_pkg::DIV_W-1:0]    elapsed_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tdt_pkg::KIND_W-1:0]   reply_kind,
  output logic                         set_ok,
  output logic [tdt_pkg::SLOT_W-1:0]   slot_number,
  output logic [tdt_pkg::TGT_W-1:0]    fired_target,
  output logic [tdt_pkg::EV_W-1:0]     fired_event,
  output logic                         last_of_run
);

  localparam int IdxW   = $clog2(SLOT_COUNT);
  localparam int SlotW  = tdt_pkg::SLOT_W;
  localparam int DivW   = tdt_pkg::DIV_W;
  localparam int EntryW = $bits(tdt_pkg::slot_entry_t);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_DIV     = 6'b000100,
    ST_WALK_RD = 6'b001000,
    ST_WALK_EV = 6'b010000,
    ST_REPLY   = 6'b100000
  } state_t;

  // Control state
  state_t                state;
  state_t                state_next;
  logic [IdxW-1:0]       idx;
  logic [IdxW-1:0]       idx_next;
  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] busy_next;
  logic [DivW-1:0]       tick_divisor;
  logic [DivW-1:0]       time_remainder;

  // Request payload held for set
  logic [tdt_pkg::CD_W-1:0]  set_delay;
  logic [tdt_pkg::TGT_W-1:0] set_target;
  logic [tdt_pkg::EV_W-1:0]  set_event;

  // Final reply waiting for the output register
  logic [tdt_pkg::KIND_W-1:0] rep_kind;
  logic [tdt_pkg::KIND_W-1:0] rep_kind_next;
  logic                       rep_ok;
  logic                       rep_ok_next;
  logic [SlotW-1:0]           rep_slot;
  logic [SlotW-1:0]           rep_slot_next;

  // Output register load
  logic                       out_load;
  logic [tdt_pkg::KIND_W-1:0] ld_kind;
  logic                       ld_ok;
  logic [SlotW-1:0]           ld_slot;
  logic [tdt_pkg::TGT_W-1:0]  ld_target;
  logic [tdt_pkg::EV_W-1:0]   ld_event;
  logic                       ld_last;

  // Memory ports
  logic                 data_we;
  logic [IdxW-1:0]      data_waddr;
  tdt_pkg::slot_entry_t data_wentry;
  logic [EntryW-1:0]    data_rdata;
  tdt_pkg::slot_entry_t rd_entry;
  logic                 cancel_we;
  logic [IdxW-1:0]      cancel_waddr;
  logic                 cancel_wdata;
  logic                 cancel_rdata;
  logic                 rd_en;

  // Divider
  logic                 div_start;
  logic [DivW:0]        sum_full;
  logic [DivW-1:0]      div_divisor;
  tdt_pkg::div_status_t div_st;

  logic accept;
  logic out_free;
  logic advance;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign rd_entry  = tdt_pkg::slot_entry_t'(data_rdata);

  // Sum of elapsed time and remainder wraps at 16 bits; a divisor of zero acts as one
  assign sum_full    = {1'b0, elapsed_time} + {1'b0, time_remainder};
  assign div_divisor = (tick_divisor == '0) ? DivW'(1) : tick_divisor;
  assign div_start   = accept && (opcode == tdt_pkg::OP_TICK);

  tdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_full[DivW-1:0]),
    .divisor  (div_divisor),
    .status   (div_st)
  );

  tdt_ram #(.WIDTH(EntryW), .DEPTH(SLOT_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wentry),
    .re    (rd_en),
    .raddr (idx),
    .rdata (data_rdata)
  );

  tdt_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_cancel_ram (
    .clk   (clk),
    .we    (cancel_we),
    .waddr (cancel_waddr),
    .wdata (cancel_wdata),
    .re    (rd_en),
    .raddr (idx),
    .rdata (cancel_rdata)
  );

  // Sequencer. Each memory entry is written at most once per slot visit and read only in
  // the next visit, so a read never overlaps a pending write to the same entry.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    busy_next     = busy;
    rep_kind_next = rep_kind;
    rep_ok_next   = rep_ok;
    rep_slot_next = rep_slot;

    data_we               = 1'b0;
    data_waddr            = idx;
    data_wentry.countdown = set_delay;
    data_wentry.target    = set_target;
    data_wentry.ev        = set_event;
    cancel_we             = 1'b0;
    cancel_waddr          = idx;
    cancel_wdata          = 1'b0;
    rd_en                 = 1'b0;

    out_load  = 1'b0;
    ld_kind   = rep_kind;
    ld_ok     = rep_ok;
    ld_slot   = rep_slot;
    ld_target = '0;
    ld_event  = '0;
    ld_last   = 1'b1;
    advance   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            tdt_pkg::OP_SET: begin
              idx_next   = '0;
              state_next = ST_SCAN;
            end
            tdt_pkg::OP_CANCEL: begin
              // drop a cancel beyond the table, acknowledge regardless
              cancel_we     = (int'(cancel_slot) < SLOT_COUNT);
              cancel_waddr  = IdxW'(cancel_slot);
              cancel_wdata  = 1'b1;
              rep_kind_next = tdt_pkg::KIND_ACK;
              rep_ok_next   = 1'b0;
              rep_slot_next = '0;
              state_next    = ST_REPLY;
            end
            tdt_pkg::OP_TICK: begin
              state_next = ST_DIV;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!busy[idx]) begin
          data_we        = 1'b1;
          cancel_we      = 1'b1;
          cancel_wdata   = 1'b0;
          busy_next[idx] = (set_delay != '0);
          rep_kind_next  = tdt_pkg::KIND_SET;
          rep_ok_next    = 1'b1;
          rep_slot_next  = SlotW'(idx);
          state_next     = ST_REPLY;
        end else if (idx == LastIdx) begin
          rep_kind_next = tdt_pkg::KIND_SET;
          rep_ok_next   = 1'b0;
          rep_slot_next = '0;
          state_next    = ST_REPLY;
        end else begin
          idx_next = idx + IdxW'(1);
        end
      end

      ST_DIV: begin
        if (!div_st.busy) begin
          idx_next   = '0;
          state_next = ST_WALK_RD;
        end
      end

      ST_WALK_RD: begin
        if (busy[idx]) begin
          rd_en      = 1'b1;
          state_next = ST_WALK_EV;
        end else if (idx == LastIdx) begin
          rep_kind_next = tdt_pkg::KIND_DONE;
          rep_ok_next   = 1'b0;
          rep_slot_next = '0;
          state_next    = ST_REPLY;
        end else begin
          idx_next = idx + IdxW'(1);
        end
      end

      ST_WALK_EV: begin
        if (cancel_rdata) begin
          busy_next[idx] = 1'b0;
          advance        = 1'b1;
        end else if (rd_entry.countdown <= div_st.quotient) begin
          // hold here until the output register frees up
          if (out_free) begin
            out_load       = 1'b1;
            ld_kind        = tdt_pkg::KIND_FIRED;
            ld_ok          = 1'b0;
            ld_slot        = SlotW'(idx);
            ld_target      = rd_entry.target;
            ld_event       = rd_entry.ev;
            ld_last        = 1'b0;
            busy_next[idx] = 1'b0;
            advance        = 1'b1;
          end
        end else begin
          data_we               = 1'b1;
          data_wentry.countdown = rd_entry.countdown - div_st.quotient;
          data_wentry.target    = rd_entry.target;
          data_wentry.ev        = rd_entry.ev;
          advance               = 1'b1;
        end
        if (advance) begin
          if (idx == LastIdx) begin
            rep_kind_next = tdt_pkg::KIND_DONE;
            rep_ok_next   = 1'b0;
            rep_slot_next = '0;
            state_next    = ST_REPLY;
          end else begin
            idx_next   = idx + IdxW'(1);
            state_next = ST_WALK_RD;
          end
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      idx            <= '0;
      busy           <= '0;
      tick_divisor   <= DivW'(1);
      time_remainder <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      busy  <= busy_next;
      if (cfg_wr_en) begin
        tick_divisor <= cfg_wr_data;
      end
      if ((state == ST_DIV) && !div_st.busy) begin
        time_remainder <= div_st.remainder;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      set_delay  <= delay_ticks;
      set_target <= target_id;
      set_event  <= event_code;
    end
    rep_kind <= rep_kind_next;
    rep_ok   <= rep_ok_next;
    rep_slot <= rep_slot_next;
    if (out_load) begin
      reply_kind   <= ld_kind;
      set_ok       <= ld_ok;
      slot_number  <= ld_slot;
      fired_target <= ld_target;
      fired_event  <= ld_event;
      last_of_run  <= ld_last;
    end
  end

  // A slot is evaluated only after a read issued for a busy slot
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_EV) |-> busy[idx])
    else $error("walk evaluates a free slot");

  // A slot taken with a non-zero delay is busy afterwards
  a_set_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !busy[idx] && set_delay != '0) |=> busy[$past(idx)])
    else $error("set did not mark its slot busy");

  // The divider runs only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> (state == ST_DIV))
    else $error("divider busy outside the divide step");

  // A fired beat is never the last beat of a run
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply_kind == tdt_pkg::KIND_FIRED) |-> !last_of_run)
    else $error("fired beat flagged as last");

  // A fired beat never leaves the block ready for a new request; the run's final reply still follows
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_load && (state == ST_WALK_EV) |=> !in_ready)
    else $error("request taken while a tick is still walking");

endmodule

`default_nettype wire

// ----- test/tdt_checker.sv -----
// Checker for the timer table: predicts each result beat from accepted requests and compares.
`timescale 1ns / 1ps

module tdt_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [tdt_pkg::OP_W-1:0]   opcode,
  input  logic [tdt_pkg::CD_W-1:0]   delay_ticks,
  input  logic [tdt_pkg::TGT_W-1:0]  target_id,
  input  logic [tdt_pkg::EV_W-1:0]   event_code,
  input  logic [tdt_pkg::SLOT_W-1:0] cancel_slot,
  input  logic [tdt_pkg::DIV_W-1:0]  elapsed_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [tdt_pkg::KIND_W-1:0] reply_kind,
  input  logic                       set_ok,
  input  logic [tdt_pkg::SLOT_W-1:0] slot_number,
  input  logic [tdt_pkg::TGT_W-1:0]  fired_target,
  input  logic [tdt_pkg::EV_W-1:0]   fired_event,
  input  logic                       last_of_run,
  output int                         fail_count,
  output int                         pending
);
  import tdt_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [TGT_W-1:0]  tgt;
    logic [EV_W-1:0]   ev;
    logic              last;
  } reply_beat_t;

  reply_beat_t      reply_q[$];
  reply_beat_t      oldest;
  logic [CD_W-1:0]  countdown [SLOTS];
  logic [TGT_W-1:0] dest [SLOTS];
  logic [EV_W-1:0]  ev_val [SLOTS];
  logic             cancelled [SLOTS];
  logic [DIV_W-1:0] remainder_acc;
  logic [DIV_W-1:0] divisor;
  int               errors = 0;

  assign fail_count = errors;

  function automatic reply_beat_t make_beat(logic [KIND_W-1:0] kind, logic ok,
                                            logic [SLOT_W-1:0] slot, logic [TGT_W-1:0] tgt,
                                            logic [EV_W-1:0] ev, logic last);
    reply_beat_t b;
    b.kind = kind;
    b.ok   = ok;
    b.slot = slot;
    b.tgt  = tgt;
    b.ev   = ev;
    b.last = last;
    return b;
  endfunction

  function automatic void release_slot(int i);
    countdown[i] = '0;
    dest[i]      = '0;
    ev_val[i]    = '0;
    cancelled[i] = 1'b0;
  endfunction

  // Apply one request to the shadow table and queue the beats it must produce.
  function automatic void apply_request(logic [OP_W-1:0] op, logic [CD_W-1:0] dly,
                                        logic [TGT_W-1:0] tgt, logic [EV_W-1:0] ev,
                                        logic [SLOT_W-1:0] cs, logic [DIV_W-1:0] el);
    logic             found;
    logic [DIV_W-1:0] div;
    logic [DIV_W-1:0] sum;
    logic [DIV_W-1:0] quot;
    found = 1'b0;
    case (op)
      OP_SET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && countdown[i] == '0) begin
            countdown[i] = dly;
            dest[i]      = tgt;
            ev_val[i]    = ev;
            cancelled[i] = 1'b0;
            found        = 1'b1;
            reply_q.push_back(make_beat(KIND_SET, 1'b1, SLOT_W'(i), '0, '0, 1'b1));
          end
        end
        if (!found)
          reply_q.push_back(make_beat(KIND_SET, 1'b0, '0, '0, '0, 1'b1));
      end
      OP_CANCEL: begin
        if (int'(cs) < SLOTS)
          cancelled[cs] = 1'b1;
        reply_q.push_back(make_beat(KIND_ACK, 1'b0, '0, '0, '0, 1'b1));
      end
      OP_TICK: begin
        div  = (divisor == '0) ? DIV_W'(1) : divisor;
        sum  = el + remainder_acc;
        quot = sum / div;
        remainder_acc = sum % div;
        for (int i = 0; i < SLOTS; i++) begin
          if (countdown[i] != '0) begin
            if (cancelled[i]) begin
              release_slot(i);
            end else if (countdown[i] <= quot) begin
              reply_q.push_back(make_beat(KIND_FIRED, 1'b0, SLOT_W'(i), dest[i], ev_val[i],
                                          1'b0));
              release_slot(i);
            end else begin
              countdown[i] = countdown[i] - quot;
            end
          end
        end
        reply_q.push_back(make_beat(KIND_DONE, 1'b0, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reply_q.delete();
      for (int i = 0; i < SLOTS; i++)
        release_slot(i);
      remainder_acc = '0;
      divisor       = DIV_W'(1);
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result beat with nothing expected: reply_kind %0d slot %0d",
                 reply_kind, slot_number);
          errors++;
        end else begin
          oldest = reply_q.pop_front();
          check_field("reply_kind", oldest.kind, reply_kind);
          check_field("set_ok", oldest.ok, set_ok);
          check_field("slot_number", oldest.slot, slot_number);
          check_field("fired_target", oldest.tgt, fired_target);
          check_field("fired_event", oldest.ev, fired_event);
          check_field("last_of_run", oldest.last, last_of_run);
        end
      end
      if (cfg_wr_en)
        divisor = cfg_wr_data;
      if (in_valid && in_ready)
        apply_request(opcode, delay_ticks, target_id, event_code, cancel_slot, elapsed_time);
    end
    pending <= reply_q.size();
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the timer table: request stimulus, divisor writes, back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;
  import tdt_pkg::*;

  // Opcode 3 is left undefined by the block; it must be swallowed without a beat.
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  // Hang guard for the whole run; this leaves ample headroom for the slowest run.
  localparam int RUN_LIMIT = 1_000_000;
  // Idle stretch after a drain, sized to outlast a tick with a full table.
  localparam int SETTLE = 100;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [15:0]         cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     opcode = '0;
  logic [CD_W-1:0]     delay_ticks = '0;
  logic [TGT_W-1:0]    target_id = '0;
  logic [EV_W-1:0]     event_code = '0;
  logic [SLOT_W-1:0]   cancel_slot = '0;
  logic [DIV_W-1:0]    elapsed_time = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   reply_kind;
  logic                set_ok;
  logic [SLOT_W-1:0]   slot_number;
  logic [TGT_W-1:0]    fired_target;
  logic [EV_W-1:0]     fired_event;
  logic                last_of_run;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  // When set, neither side inserts idle cycles any more.
  logic calm = 1'b0;
  // Divisor currently programmed, used only to scale tick stimulus.
  int   divisor_now = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deferred_event_timer_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .delay_ticks  (delay_ticks),
    .target_id    (target_id),
    .event_code   (event_code),
    .cancel_slot  (cancel_slot),
    .elapsed_time (elapsed_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_kind   (reply_kind),
    .set_ok       (set_ok),
    .slot_number  (slot_number),
    .fired_target (fired_target),
    .fired_event  (fired_event),
    .last_of_run  (last_of_run)
  );

  tdt_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .delay_ticks  (delay_ticks),
    .target_id    (target_id),
    .event_code   (event_code),
    .cancel_slot  (cancel_slot),
    .elapsed_time (elapsed_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_kind   (reply_kind),
    .set_ok       (set_ok),
    .slot_number  (slot_number),
    .fired_target (fired_target),
    .fired_event  (fired_event),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Abandon the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: stall in random bursts, long ready stretches in between; no stalls once calm.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Present one request beat and hold it until the block takes it.
  task automatic send(input logic [OP_W-1:0] op, input logic [CD_W-1:0] dly,
                      input logic [TGT_W-1:0] tgt, input logic [EV_W-1:0] ev,
                      input logic [SLOT_W-1:0] cs, input logic [DIV_W-1:0] el);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    delay_ticks  <= dly;
    target_id    <= tgt;
    event_code   <= ev;
    cancel_slot  <= cs;
    elapsed_time <= el;
    do @(posedge clk); while (!in_ready);
  endtask

  // Unused fields carry random noise so every input bit toggles.
  task automatic set_timer(input logic [CD_W-1:0] dly, input logic [TGT_W-1:0] tgt,
                           input logic [EV_W-1:0] ev);
    send(OP_SET, dly, tgt, ev, SLOT_W'($urandom), DIV_W'($urandom));
  endtask

  task automatic cancel_timer(input logic [SLOT_W-1:0] cs);
    send(OP_CANCEL, CD_W'($urandom), TGT_W'($urandom), EV_W'($urandom), cs, DIV_W'($urandom));
  endtask

  task automatic tick(input logic [DIV_W-1:0] el);
    send(OP_TICK, CD_W'($urandom), TGT_W'($urandom), EV_W'($urandom), SLOT_W'($urandom), el);
  endtask

  // Drop valid and hold until every expected beat is back, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [15:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    divisor_now = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly short delays so timers fire soon; free slots and full-range values now and then.
  function automatic logic [CD_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CD_W'($urandom_range(1, 65535));
      default: return CD_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Elapsed time mostly scaled to the divisor for small non-zero quotients; edge and random values too.
  function automatic logic [DIV_W-1:0] pick_elapsed();
    longint div;
    longint span;
    div = (divisor_now == 0) ? 1 : divisor_now;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return DIV_W'($urandom_range(0, 65535));
      3:       return DIV_W'($urandom_range(0, int'(div) - 1));
      default: begin
        span = div * $urandom_range(1, 6) + $urandom_range(0, int'(div) - 1);
        if (span > 65535)
          span = 65535;
        return DIV_W'(span);
      end
    endcase
  endfunction

  // Mix of sets, cancels (biased to the low slots that sets claim), ticks and the odd undefined opcode.
  task automatic random_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 19);
      if (pick <= 8)
        set_timer(pick_delay(), TGT_W'($urandom), EV_W'($urandom));
      else if (pick <= 12)
        cancel_timer($urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 7)) : SLOT_W'($urandom));
      else if (pick <= 18)
        tick(pick_elapsed());
      else
        send(OP_UNDEF, CD_W'($urandom), TGT_W'($urandom), EV_W'($urandom),
             SLOT_W'($urandom), DIV_W'($urandom));
    end
  endtask

  // Overfill the table, cancel a few slots, then tick hard to empty it again.
  task automatic fill_table(input logic short_delays);
    repeat (34)
      set_timer(short_delays ? CD_W'($urandom_range(1, 8)) : CD_W'($urandom_range(1, 65535)),
                TGT_W'($urandom), EV_W'($urandom));
    repeat (3)
      cancel_timer(SLOT_W'($urandom));
    tick('1);
    tick('1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset divisor of 1.
    tick('0);                       // walk of an empty table
    set_timer('0, '0, '0);          // zero delay: succeeds, slot stays free
    set_timer('1, '1, '1);          // longest delay, largest target and event
    set_timer(16'd1, 4'd5, 8'hA5);
    set_timer(16'd2, 4'd10, 8'h5A);
    cancel_timer(5'd31);            // cancel of a free slot: mark waits for the next set
    cancel_timer(5'd2);             // cancel of a live timer
    send(OP_UNDEF, '1, '1, '1, '1, '1);
    tick(16'd1);                    // one fires, the cancelled one goes silently
    set_timer(16'd3, 4'd3, 8'd3);
    set_timer(16'd3, 4'd12, 8'hC3);
    tick('1);                       // several fire in one walk
    cancel_timer(5'd0);
    set_timer(16'd5, 4'd9, 8'h99);  // set clears the stale cancel mark
    tick(16'd4);
    tick(16'd1);
    set_timer(16'd7, 4'd1, 8'd1);
    cancel_timer(5'd0);
    tick('1);

    // Full table and its recovery; slot 31 still carries the stale mark from above.
    fill_table(1'b0);

    write_divisor(16'd0);           // zero behaves as one
    random_mix(40);

    write_divisor(16'hFFFF);        // remainder near the top, sum wraps
    random_mix(20);
    drain();                        // hold the sender until every result is back
    random_mix(20);

    write_divisor(16'd3);
    fill_table(1'b1);
    random_mix(40);

    write_divisor(16'($urandom_range(2, 50)));
    random_mix(40);

    write_divisor(16'd1000);
    random_mix(13);

    // Final stretch with no idling on either side.
    write_divisor(16'd1);
    calm = 1'b1;
    random_mix(40);

    drain();
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
